### design/afsm_pkg.sv
// afsm_pkg: shared types and constants for the frame sequencer and mixer
// no dependencies; used by the interfaces and every module but the checker
`timescale 1ns / 1ps

package afsm_pkg;

   // input function codes
   localparam logic [1:0] FUNC_TICK  = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;

   // register offsets from 0x4000
   localparam logic [4:0] OFF_STATUS = 5'h15;
   localparam logic [4:0] OFF_FRAME  = 5'h17;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_PERIOD  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_PERIOD = 4'd1;
   localparam int unsigned CSR_DATA_W = 14;

   localparam logic [13:0] FRAME_PERIOD_RESET  = 14'd7457;
   localparam logic [7:0]  SAMPLE_PERIOD_RESET = 8'd40;

   // mixer tables: entry i = round(scale * i * 51200 / (base + 100 i))
   localparam int unsigned PULSE_ROM_DEPTH = 31;
   localparam int unsigned TND_ROM_DEPTH   = 203;
   localparam int unsigned ROM_W           = 22;
   localparam longint unsigned PULSE_SCALE = 64'd9552;
   localparam longint unsigned PULSE_BASE  = 64'd8128;
   localparam longint unsigned TND_SCALE   = 64'd16367;
   localparam longint unsigned TND_BASE    = 64'd24329;
   localparam longint unsigned ROM_GAIN    = 64'd51200;
   localparam longint unsigned ROM_SLOPE   = 64'd100;

   typedef struct packed {
      logic [1:0] func;
      logic [4:0] reg_offset;
      logic [7:0] wdata;
      logic [3:0] pulse1_level;
      logic [3:0] pulse2_level;
      logic [3:0] triangle_level;
      logic [3:0] noise_level;
      logic [3:0] length_active;
   } req_item_type;

   typedef struct packed {
      logic        quarter_frame;
      logic        half_frame;
      logic        irq;
      logic        sample_valid;
      logic [14:0] sample;
      logic [7:0]  read_data;
      logic [3:0]  channel_enables;
   } rsp_item_type;

   // sequencer outcome for one item
   typedef struct packed {
      logic       quarter_frame;
      logic       half_frame;
      logic       irq;
      logic       sample_fire;
      logic [7:0] read_data;
      logic [3:0] channel_enables;
   } seq_result_type;

endpackage

### design/afsm_if.sv
// afsm_if: valid/ready channel interfaces for request, response and csr write
// depends on afsm_pkg
`timescale 1ns / 1ps

interface afsm_req_if;
   import afsm_pkg::*;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [4:0] reg_offset;
   logic [7:0] wdata;
   logic [3:0] pulse1_level;
   logic [3:0] pulse2_level;
   logic [3:0] triangle_level;
   logic [3:0] noise_level;
   logic [3:0] length_active;

   modport source (output valid, func, reg_offset, wdata, pulse1_level, pulse2_level,
                   triangle_level, noise_level, length_active, input ready);
   modport sink (input valid, func, reg_offset, wdata, pulse1_level, pulse2_level,
                 triangle_level, noise_level, length_active, output ready);
endinterface

interface afsm_rsp_if;
   import afsm_pkg::*;
   logic        valid;
   logic        ready;
   logic        quarter_frame;
   logic        half_frame;
   logic        irq;
   logic        sample_valid;
   logic [14:0] sample;
   logic [7:0]  read_data;
   logic [3:0]  channel_enables;

   modport source (output valid, quarter_frame, half_frame, irq, sample_valid, sample,
                   read_data, channel_enables, input ready);
   modport sink (input valid, quarter_frame, half_frame, irq, sample_valid, sample,
                 read_data, channel_enables, output ready);
endinterface

interface afsm_csr_if;
   import afsm_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### design/afsm_seq.sv
// afsm_seq: frame divider, step sequencer, sample divider and status registers
// depends on afsm_pkg
`timescale 1ns / 1ps

module afsm_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    item_fire,
   input  afsm_pkg::req_item_type  item,
   input  logic [13:0]             frame_period,
   input  logic [7:0]              sample_period,
   output afsm_pkg::seq_result_type result
);
   import afsm_pkg::*;

   logic [13:0] cycle_count_ff, cycle_count_in;
   logic [2:0]  step_count_ff, step_count_in;
   logic        five_step_ff, five_step_in;
   logic        irq_inhibit_ff, irq_inhibit_in;
   logic        irq_flag_ff, irq_flag_in;
   logic [3:0]  enable_bits_ff, enable_bits_in;
   logic [7:0]  sample_count_ff, sample_count_in;
   logic [13:0] cycle_inc;
   logic [7:0]  sample_inc;
   logic [2:0]  step_inc;

   always_comb begin
      cycle_count_in  = cycle_count_ff;
      step_count_in   = step_count_ff;
      five_step_in    = five_step_ff;
      irq_inhibit_in  = irq_inhibit_ff;
      irq_flag_in     = irq_flag_ff;
      enable_bits_in  = enable_bits_ff;
      sample_count_in = sample_count_ff;
      cycle_inc       = cycle_count_ff + 14'd1;
      sample_inc      = sample_count_ff + 8'd1;
      step_inc        = step_count_ff + 3'd1;
      result          = '0;

      unique case (item.func)
         FUNC_TICK: begin
            cycle_count_in = cycle_inc;
            if (cycle_inc >= frame_period) begin
               cycle_count_in = '0;
               step_count_in  = step_inc;
               if (five_step_ff) begin
                  result.quarter_frame = (step_inc < 3'd4) || (step_inc == 3'd5);
                  result.half_frame    = (step_inc == 3'd2) || (step_inc == 3'd5);
                  if (step_inc == 3'd5) begin
                     step_count_in = '0;
                  end
               end else begin
                  result.quarter_frame = 1'b1;
                  result.half_frame    = ~step_inc[0];
                  if (step_inc == 3'd4) begin
                     if (!irq_inhibit_ff) begin
                        irq_flag_in = 1'b1;
                     end
                     step_count_in = '0;
                  end
               end
            end
            sample_count_in = sample_inc;
            if (sample_inc >= sample_period) begin
               sample_count_in    = '0;
               result.sample_fire = 1'b1;
            end
         end
         FUNC_WRITE: begin
            if (item.reg_offset == OFF_STATUS) begin
               enable_bits_in = item.wdata[3:0];
            end else if (item.reg_offset == OFF_FRAME) begin
               five_step_in   = item.wdata[7];
               irq_inhibit_in = item.wdata[6];
               cycle_count_in = '0;
               step_count_in  = '0;
               if (item.wdata[6]) begin
                  irq_flag_in = 1'b0;
               end
            end
         end
         FUNC_READ: begin
            if (item.reg_offset == OFF_STATUS) begin
               result.read_data = {1'b0, irq_flag_ff, 2'b00, item.length_active};
               irq_flag_in      = 1'b0;
            end
         end
         default: begin
         end
      endcase

      result.irq             = irq_flag_in;
      result.channel_enables = enable_bits_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cycle_count_ff  <= '0;
         step_count_ff   <= '0;
         five_step_ff    <= 1'b0;
         irq_inhibit_ff  <= 1'b0;
         irq_flag_ff     <= 1'b0;
         enable_bits_ff  <= '0;
         sample_count_ff <= '0;
      end else if (item_fire) begin
         cycle_count_ff  <= cycle_count_in;
         step_count_ff   <= step_count_in;
         five_step_ff    <= five_step_in;
         irq_inhibit_ff  <= irq_inhibit_in;
         irq_flag_ff     <= irq_flag_in;
         enable_bits_ff  <= enable_bits_in;
         sample_count_ff <= sample_count_in;
      end
   end

endmodule

### design/afsm_mix.sv
// afsm_mix: nonlinear four-channel mixer, two constant lookup tables and a sum
// depends on afsm_pkg
`timescale 1ns / 1ps

module afsm_mix (
   input  logic [3:0]  pulse1_level,
   input  logic [3:0]  pulse2_level,
   input  logic [3:0]  triangle_level,
   input  logic [3:0]  noise_level,
   output logic [14:0] sample
);
   import afsm_pkg::*;

   logic [ROM_W-1:0] pulse_rom [PULSE_ROM_DEPTH];
   logic [ROM_W-1:0] tnd_rom [TND_ROM_DEPTH];
   logic [4:0]       pulse_idx;
   logic [6:0]       tnd_idx;
   logic [ROM_W:0]   mix_sum;

   // tables built at elaboration, rounded to nearest in Q.8
   for (genvar g = 0; g < PULSE_ROM_DEPTH; g++) begin : g_pulse_rom
      localparam longint unsigned NUM = PULSE_SCALE * 64'(g) * ROM_GAIN;
      localparam longint unsigned DEN = PULSE_BASE + ROM_SLOPE * 64'(g);
      localparam longint unsigned VAL = (g == 0) ? 64'd0 : (NUM + DEN / 2) / DEN;
      assign pulse_rom[g] = VAL[ROM_W-1:0];
   end

   for (genvar g = 0; g < TND_ROM_DEPTH; g++) begin : g_tnd_rom
      localparam longint unsigned NUM = TND_SCALE * 64'(g) * ROM_GAIN;
      localparam longint unsigned DEN = TND_BASE + ROM_SLOPE * 64'(g);
      localparam longint unsigned VAL = (g == 0) ? 64'd0 : (NUM + DEN / 2) / DEN;
      assign tnd_rom[g] = VAL[ROM_W-1:0];
   end

   // pulse index tops out at 30, tnd index at 75: both stay in range
   assign pulse_idx = {1'b0, pulse1_level} + {1'b0, pulse2_level};
   assign tnd_idx   = {2'b00, triangle_level, 1'b0} + {3'b000, triangle_level}
                    + {2'b00, noise_level, 1'b0};
   assign mix_sum   = {1'b0, pulse_rom[pulse_idx]} + {1'b0, tnd_rom[{1'b0, tnd_idx}]};
   assign sample    = mix_sum[ROM_W:8];

endmodule

### design/apu_frame_sequencer_and_mixer.sv
// apu_frame_sequencer_and_mixer: top level, input and result registers, csr block
// depends on afsm_pkg, afsm_if, afsm_seq and afsm_mix
`timescale 1ns / 1ps

// usage
//  - req_chan carries one item per transfer: a cpu cycle tick, a register
//    write (0x4015 enables, 0x4017 mode/inhibit) or a register read (0x4015
//    status), together with the four channel levels and length-active bits
//  - rsp_chan returns exactly one result per request: frame strobes, irq level,
//    an optional mixed sample, the read byte and the channel enables
//  - csr_chan writes frame_period (index 0) and sample_period (index 1); it is
//    always ready and must only be used while no request is in flight
//  - from request transfer to result valid an item passes the input register,
//    then sequencer and mixer logic into the result register
//  - throughput: one item per cycle while rsp is not stalled, set by the
//    sequencer state update and the table lookup plus one 23-bit add feeding
//    the result register
//  - when rsp is stalled the result holds, the input register still takes one
//    more item, and then req_ready drops until the result drains
//  - synchronous reset empties both registers, clears the sequencer state and
//    reloads the periods to 7457 and 40
module apu_frame_sequencer_and_mixer (
   input logic      clock,
   input logic      reset,
   afsm_req_if.sink   req_chan,
   afsm_rsp_if.source rsp_chan,
   afsm_csr_if.sink   csr_chan
);
   import afsm_pkg::*;

   logic           in_valid_ff;
   req_item_type   in_item_ff;
   logic           rsp_valid_ff;
   rsp_item_type   rsp_item_ff;
   rsp_item_type   rsp_item_in;
   logic [13:0]    frame_period_ff;
   logic [7:0]     sample_period_ff;
   logic           advance;
   logic           req_take;
   seq_result_type seq_res;
   logic [14:0]    mix_sample;

   // the input stage moves on whenever the result register is free or draining
   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_period_ff  <= FRAME_PERIOD_RESET;
         sample_period_ff <= SAMPLE_PERIOD_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_FRAME_PERIOD:  frame_period_ff  <= csr_chan.data[13:0];
            CSR_SAMPLE_PERIOD: sample_period_ff <= csr_chan.data[7:0];
            default: begin
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.func           <= req_chan.func;
         in_item_ff.reg_offset     <= req_chan.reg_offset;
         in_item_ff.wdata          <= req_chan.wdata;
         in_item_ff.pulse1_level   <= req_chan.pulse1_level;
         in_item_ff.pulse2_level   <= req_chan.pulse2_level;
         in_item_ff.triangle_level <= req_chan.triangle_level;
         in_item_ff.noise_level    <= req_chan.noise_level;
         in_item_ff.length_active  <= req_chan.length_active;
      end
   end

   // sequencer state commits as the item leaves the input register
   afsm_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .item_fire     (advance),
      .item          (in_item_ff),
      .frame_period  (frame_period_ff),
      .sample_period (sample_period_ff),
      .result        (seq_res)
   );

   afsm_mix u_mix (
      .pulse1_level   (in_item_ff.pulse1_level),
      .pulse2_level   (in_item_ff.pulse2_level),
      .triangle_level (in_item_ff.triangle_level),
      .noise_level    (in_item_ff.noise_level),
      .sample         (mix_sample)
   );

   always_comb begin
      rsp_item_in.quarter_frame   = seq_res.quarter_frame;
      rsp_item_in.half_frame      = seq_res.half_frame;
      rsp_item_in.irq             = seq_res.irq;
      rsp_item_in.sample_valid    = seq_res.sample_fire;
      rsp_item_in.sample          = seq_res.sample_fire ? mix_sample : 15'd0;
      rsp_item_in.read_data       = seq_res.read_data;
      rsp_item_in.channel_enables = seq_res.channel_enables;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.quarter_frame   = rsp_item_ff.quarter_frame;
   assign rsp_chan.half_frame      = rsp_item_ff.half_frame;
   assign rsp_chan.irq             = rsp_item_ff.irq;
   assign rsp_chan.sample_valid    = rsp_item_ff.sample_valid;
   assign rsp_chan.sample          = rsp_item_ff.sample;
   assign rsp_chan.read_data       = rsp_item_ff.read_data;
   assign rsp_chan.channel_enables = rsp_item_ff.channel_enables;

endmodule

### design/afsm_checker.sv
// afsm_checker: port-level assertions for the frame sequencer and mixer
// depends on afsm_if through the bind to apu_frame_sequencer_and_mixer
`timescale 1ns / 1ps

module afsm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        quarter_frame,
   input logic        half_frame,
   input logic        sample_valid,
   input logic [14:0] sample,
   input logic [7:0]  read_data
);

   // a stalled result keeps its sample
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(sample))
      else $error("stalled result changed");

   // half-frame strobes only come with a quarter-frame strobe
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && half_frame |-> quarter_frame)
      else $error("half frame without quarter frame");

   // no sample value without a sample strobe
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !sample_valid |-> sample == 15'd0)
      else $error("sample set without sample_valid");

   // tick results carry no read byte, and status has only irq and length bits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (quarter_frame || sample_valid || read_data[7] || read_data[5] ||
                    read_data[4]) |-> read_data == 8'd0)
      else $error("bad read byte");

   // the result register is empty right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind apu_frame_sequencer_and_mixer afsm_checker u_afsm_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .quarter_frame (rsp_chan.quarter_frame),
   .half_frame    (rsp_chan.half_frame),
   .sample_valid  (rsp_chan.sample_valid),
   .sample        (rsp_chan.sample),
   .read_data     (rsp_chan.read_data)
);

### tb/sv/apu_frame_sequencer_and_mixer_test.sv
// apu_frame_sequencer_and_mixer_test: self-checking bench for the frame sequencer and mixer
// depends on afsm_pkg, the afsm interfaces and the apu_frame_sequencer_and_mixer rtl
`timescale 1ns / 1ps

module apu_frame_sequencer_and_mixer_test;
   import afsm_pkg::*;

   // codes the package leaves out
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = '1;

   // phases with extra behavior
   localparam int PAUSE_PHASE = 3;
   localparam int ZERO_PHASE  = 4;
   localparam int HOLD_PHASE  = 5;
   localparam int HOLD_CYCLES = 80;
   localparam int MAX_REPORTS = 10;

   logic clock;
   logic reset;

   afsm_req_if req_chan();
   afsm_rsp_if rsp_chan();
   afsm_csr_if csr_chan();

   apu_frame_sequencer_and_mixer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // ---------------------------------------------------------------
   // directed rows: levels share one value, known rows carry the
   // expected read byte and enables (strobes, irq and sample are zero)
   // ---------------------------------------------------------------
   typedef struct {
      logic [1:0] func;
      logic [4:0] offset;
      logic [7:0] wdata;
      logic [3:0] level;
      logic [3:0] lact;
      bit         known;
      logic [7:0] read_byte;
      logic [3:0] enables;
   } directed_row_type;

   directed_row_type directed_rows [24] = '{
      '{FUNC_TICK,   5'h00,      8'h00, 4'h0, 4'h0, 1'b1, 8'h00, 4'h0},  // quiet tick
      '{FUNC_TICK,   5'h1f,      8'hff, 4'hf, 4'hf, 1'b0, 8'h00, 4'h0},  // all ones tick
      '{FUNC_READ,   OFF_STATUS, 8'h00, 4'h0, 4'hf, 1'b1, 8'h0f, 4'h0},  // status, all active
      '{FUNC_READ,   OFF_STATUS, 8'hff, 4'hf, 4'h0, 1'b1, 8'h00, 4'h0},
      '{FUNC_READ,   5'h00,      8'hff, 4'hf, 4'hf, 1'b1, 8'h00, 4'h0},  // other offsets read 0
      '{FUNC_READ,   5'h1f,      8'h00, 4'h0, 4'hf, 1'b1, 8'h00, 4'h0},
      '{FUNC_READ,   OFF_FRAME,  8'h00, 4'h0, 4'hf, 1'b1, 8'h00, 4'h0},
      '{FUNC_WRITE,  OFF_STATUS, 8'hff, 4'h0, 4'h0, 1'b1, 8'h00, 4'hf},  // enables from low nibble
      '{FUNC_WRITE,  OFF_STATUS, 8'hf0, 4'hf, 4'hf, 1'b1, 8'h00, 4'h0},
      '{FUNC_WRITE,  OFF_STATUS, 8'h05, 4'h0, 4'h0, 1'b1, 8'h00, 4'h5},
      '{FUNC_WRITE,  5'h00,      8'hff, 4'hf, 4'hf, 1'b1, 8'h00, 4'h5},  // ignored writes
      '{FUNC_WRITE,  5'h1f,      8'h0a, 4'h0, 4'h0, 1'b1, 8'h00, 4'h5},
      '{FUNC_WRITE,  5'h14,      8'hff, 4'hf, 4'hf, 1'b1, 8'h00, 4'h5},
      '{FUNC_WRITE,  5'h16,      8'hff, 4'hf, 4'hf, 1'b1, 8'h00, 4'h5},
      '{FUNC_WRITE,  OFF_FRAME,  8'hc0, 4'h0, 4'h0, 1'b1, 8'h00, 4'h5},  // five-step, inhibit
      '{FUNC_WRITE,  OFF_FRAME,  8'h80, 4'hf, 4'hf, 1'b1, 8'h00, 4'h5},
      '{FUNC_WRITE,  OFF_FRAME,  8'h40, 4'h0, 4'h0, 1'b1, 8'h00, 4'h5},
      '{FUNC_WRITE,  OFF_FRAME,  8'h00, 4'hf, 4'hf, 1'b1, 8'h00, 4'h5},
      '{FUNC_UNUSED, 5'h1f,      8'hff, 4'hf, 4'hf, 1'b1, 8'h00, 4'h5},  // unused function
      '{FUNC_WRITE,  OFF_STATUS, 8'h0a, 4'h0, 4'h0, 1'b1, 8'h00, 4'ha},
      '{FUNC_TICK,   5'h00,      8'h00, 4'hf, 4'hf, 1'b0, 8'h00, 4'ha},
      '{FUNC_TICK,   OFF_STATUS, 8'hff, 4'h0, 4'h0, 1'b0, 8'h00, 4'ha},  // tick ignores offset
      '{FUNC_READ,   OFF_STATUS, 8'h00, 4'h0, 4'h5, 1'b1, 8'h05, 4'ha},
      '{FUNC_TICK,   5'h15,      8'h80, 4'hf, 4'h0, 1'b0, 8'h00, 4'ha}
   };

   // ---------------------------------------------------------------
   // period settings walked by the random part; phase 0 keeps reset values
   // ---------------------------------------------------------------
   typedef struct {
      logic [CSR_DATA_W-1:0] frame;
      logic [CSR_DATA_W-1:0] sample_word;
      int                    items;
      bit                    idling;
   } phase_type;

   phase_type phase_plan [8] = '{
      '{14'd0,     14'd0,      60,  1'b1},  // reset periods
      '{14'd16383, 14'd255,    60,  1'b1},  // both at their maximum
      '{14'd3,     14'd1,      130, 1'b0},  // lowered period, no idling at all
      '{14'd1,     14'd2,      100, 1'b1},  // sender pause in the middle
      '{14'd0,     14'd0,      60,  1'b1},  // zero periods fire every tick
      '{14'd5,     14'd7,      140, 1'b1},  // long receiver hold at the start
      '{14'd2,     14'h3f2c,   100, 1'b1},  // sample period keeps low byte only
      '{14'd9,     14'd3,      130, 1'b1}
   };

   // ---------------------------------------------------------------
   // predictor state
   // ---------------------------------------------------------------
   logic [13:0]       frame_period_cfg;
   logic [7:0]        sample_period_cfg;
   logic [13:0]       frame_divider;
   logic [2:0]        step_index;
   bit                five_step;
   bit                irq_inhibit;
   bit                irq_pending;
   logic [3:0]        enables;
   logic [7:0]        sample_divider;
   longint unsigned   pulse_table [31];
   longint unsigned   tnd_table [203];

   rsp_item_type      outstanding [$];

   // shared between the sender and receiver processes
   bit                idling_on;
   bit                hold_armed;
   int                hold_left;

   int                mismatches;
   int                results_seen;
   int                samples_seen;
   int                quarters_seen;
   int                halves_seen;
   int                irq_reports;
   int                items_sent;
   int                csr_writes;

   // one result for one accepted item, state advanced in place
   function automatic rsp_item_type step_frame_and_mix(input req_item_type it);
      rsp_item_type res;
      int unsigned  pulse_idx;
      int unsigned  tnd_idx;
      res = '0;
      case (it.func)
         FUNC_TICK: begin
            frame_divider = frame_divider + 14'd1;
            if (frame_divider >= frame_period_cfg) begin
               frame_divider = '0;
               step_index = step_index + 3'd1;
               if (five_step) begin
                  // quarter on 1,2,3,5, half on 2 and 5, never an irq
                  res.quarter_frame = (step_index < 3'd4) || (step_index == 3'd5);
                  res.half_frame = (step_index == 3'd2) || (step_index == 3'd5);
                  if (step_index == 3'd5)
                     step_index = '0;
               end else begin
                  res.quarter_frame = 1'b1;
                  res.half_frame = !step_index[0];
                  if (step_index == 3'd4) begin
                     if (!irq_inhibit)
                        irq_pending = 1'b1;
                     step_index = '0;
                  end
               end
            end
            sample_divider = sample_divider + 8'd1;
            if (sample_divider >= sample_period_cfg) begin
               sample_divider = '0;
               pulse_idx = 32'(it.pulse1_level) + 32'(it.pulse2_level);
               tnd_idx = 3 * 32'(it.triangle_level) + 2 * 32'(it.noise_level);
               res.sample_valid = 1'b1;
               res.sample = 15'((pulse_table[pulse_idx] + tnd_table[tnd_idx]) >> 8);
            end
         end
         FUNC_WRITE: begin
            if (it.reg_offset == OFF_STATUS) begin
               enables = it.wdata[3:0];
            end else if (it.reg_offset == OFF_FRAME) begin
               five_step = it.wdata[7];
               irq_inhibit = it.wdata[6];
               frame_divider = '0;
               step_index = '0;
               if (irq_inhibit)
                  irq_pending = 1'b0;
            end
         end
         FUNC_READ: begin
            if (it.reg_offset == OFF_STATUS) begin
               res.read_data = {1'b0, irq_pending, 2'b00, it.length_active};
               irq_pending = 1'b0;
            end
         end
         default: ;
      endcase
      res.irq = irq_pending;
      res.channel_enables = enables;
      return res;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int unsigned roll;
      if (!idling_on)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      else if (roll < 88)
         return $urandom_range(1, 3);
      else if (roll < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [3:0] random_level();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll == 0)
         return 4'h0;
      else if (roll == 1)
         return 4'hf;
      return 4'($urandom_range(0, 15));
   endfunction

   // mostly ticks, with status traffic, frame writes and some noise
   function automatic req_item_type random_request();
      req_item_type it;
      int unsigned  roll;
      it.func = FUNC_TICK;
      it.reg_offset = 5'($urandom);
      it.wdata = 8'($urandom);
      it.pulse1_level = random_level();
      it.pulse2_level = random_level();
      it.triangle_level = random_level();
      it.noise_level = random_level();
      it.length_active = 4'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 84) begin
         it.func = FUNC_TICK;
      end else if (roll < 90) begin
         it.func = FUNC_READ;
         it.reg_offset = OFF_STATUS;
      end else if (roll < 95) begin
         it.func = FUNC_WRITE;
         it.reg_offset = OFF_STATUS;
      end else if (roll < 97) begin
         it.func = FUNC_WRITE;
         it.reg_offset = OFF_FRAME;
      end else begin
         // any function at any offset
         it.func = 2'($urandom);
      end
      return it;
   endfunction

   // drive one item and return at the edge where it transfers
   task automatic offer_request(input req_item_type it, input int gap);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.func           <= it.func;
      req_chan.reg_offset     <= it.reg_offset;
      req_chan.wdata          <= it.wdata;
      req_chan.pulse1_level   <= it.pulse1_level;
      req_chan.pulse2_level   <= it.pulse2_level;
      req_chan.triangle_level <= it.triangle_level;
      req_chan.noise_level    <= it.noise_level;
      req_chan.length_active  <= it.length_active;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
   endtask

   // csr valid is left high; the caller lowers it after the last write
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      case (idx)
         CSR_FRAME_PERIOD:  frame_period_cfg = value;
         CSR_SAMPLE_PERIOD: sample_period_cfg = value[7:0];
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic check_field(input string name, input logic [14:0] want_v,
                              input logic [14:0] got_v);
      if (got_v !== want_v) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("mismatch on result %0d, %s: expected %0d, got %0d",
                     results_seen, name, want_v, got_v);
      end
   endtask

   // ---------------------------------------------------------------
   // clock and limit
   // ---------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d results outstanding", outstanding.size());
      $display("apu_frame_sequencer_and_mixer_test failed");
      $finish;
   end

   // ---------------------------------------------------------------
   // mixer tables, rounded to nearest with halves up
   // ---------------------------------------------------------------
   initial begin
      longint unsigned den;
      for (int i = 0; i < 31; i++) begin
         den = 64'd8128 + 64'd100 * i;
         pulse_table[i] = (i == 0) ? 0 : (64'd9552 * i * 64'd51200 + den / 2) / den;
      end
      for (int i = 0; i < 203; i++) begin
         den = 64'd24329 + 64'd100 * i;
         tnd_table[i] = (i == 0) ? 0 : (64'd16367 * i * 64'd51200 + den / 2) / den;
      end
   end

   // ---------------------------------------------------------------
   // receiver: random stalls plus one long hold counted here
   // ---------------------------------------------------------------
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_armed) begin
            hold_armed = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   // ---------------------------------------------------------------
   // checker: every result transfer against the oldest expectation
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         results_seen++;
         if (outstanding.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("result %0d arrived with nothing outstanding", results_seen);
         end else begin
            want = outstanding.pop_front();
            check_field("quarter_frame", 15'(want.quarter_frame),
                        15'(rsp_chan.quarter_frame));
            check_field("half_frame", 15'(want.half_frame), 15'(rsp_chan.half_frame));
            check_field("irq", 15'(want.irq), 15'(rsp_chan.irq));
            check_field("sample_valid", 15'(want.sample_valid),
                        15'(rsp_chan.sample_valid));
            check_field("sample", want.sample, rsp_chan.sample);
            check_field("read_data", 15'(want.read_data), 15'(rsp_chan.read_data));
            check_field("channel_enables", 15'(want.channel_enables),
                        15'(rsp_chan.channel_enables));
            samples_seen  += int'(want.sample_valid);
            quarters_seen += int'(want.quarter_frame);
            halves_seen   += int'(want.half_frame);
            irq_reports   += int'(want.read_data[6]);
         end
      end
   end

   // ---------------------------------------------------------------
   // stimulus: directed rows, then random phases over period settings
   // ---------------------------------------------------------------
   initial begin
      req_item_type item;
      rsp_item_type want;
      directed_row_type row;
      int gap;
      int waited;
      int leftover;

      // predictor starts from reset values
      frame_period_cfg  = FRAME_PERIOD_RESET;
      sample_period_cfg = SAMPLE_PERIOD_RESET;
      frame_divider     = '0;
      step_index        = '0;
      five_step         = 1'b0;
      irq_inhibit       = 1'b0;
      irq_pending       = 1'b0;
      enables           = '0;
      sample_divider    = '0;
      idling_on         = 1'b1;
      hold_armed        = 1'b0;
      hold_left         = 0;

      reset                   <= 1'b1;
      req_chan.valid          <= 1'b0;
      req_chan.func           <= FUNC_TICK;
      req_chan.reg_offset     <= '0;
      req_chan.wdata          <= '0;
      req_chan.pulse1_level   <= '0;
      req_chan.pulse2_level   <= '0;
      req_chan.triangle_level <= '0;
      req_chan.noise_level    <= '0;
      req_chan.length_active  <= '0;
      csr_chan.valid          <= 1'b0;
      csr_chan.index          <= CSR_FRAME_PERIOD;
      csr_chan.data           <= '0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed part at reset periods
      for (int r = 0; r < 24; r++) begin
         row = directed_rows[r];
         item.func           = row.func;
         item.reg_offset     = row.offset;
         item.wdata          = row.wdata;
         item.pulse1_level   = row.level;
         item.pulse2_level   = row.level;
         item.triangle_level = row.level;
         item.noise_level    = row.level;
         item.length_active  = row.lact;
         offer_request(item, pick_gap());
         want = step_frame_and_mix(item);
         if (row.known)
            want = '{1'b0, 1'b0, 1'b0, 1'b0, 15'd0, row.read_byte, row.enables};
         outstanding.push_back(want);
      end

      for (int p = 0; p < 8; p++) begin
         if (p > 0) begin
            // periods change only with nothing in flight
            req_chan.valid <= 1'b0;
            do @(posedge clock); while (outstanding.size() != 0);
            write_csr(CSR_FRAME_PERIOD, phase_plan[p].frame);
            write_csr(CSR_SAMPLE_PERIOD, phase_plan[p].sample_word);
            if (p == ZERO_PHASE)
               write_csr(CSR_UNUSED_INDEX, '1);
            csr_chan.valid <= 1'b0;
         end
         idling_on = phase_plan[p].idling;
         if (p == HOLD_PHASE)
            hold_armed = 1'b1;

         for (int n = 0; n < phase_plan[p].items; n++) begin
            if (p == PAUSE_PHASE && n == phase_plan[p].items / 2) begin
               // sender waits for the block to drain completely
               req_chan.valid <= 1'b0;
               do @(posedge clock); while (outstanding.size() != 0);
            end
            item = random_request();
            // keep offering while the receiver holds off so the block backs up
            gap = (hold_armed || hold_left > 0) ? 0 : pick_gap();
            offer_request(item, gap);
            outstanding.push_back(step_frame_and_mix(item));
         end
      end

      req_chan.valid <= 1'b0;
      for (waited = 0; waited < 5000 && outstanding.size() != 0; waited++)
         @(posedge clock);
      repeat (10) @(posedge clock);
      leftover = outstanding.size();
      if (leftover != 0) begin
         mismatches += leftover;
         $display("%0d expected results never arrived", leftover);
      end

      $display("covered %0d items (24 directed) over 8 period settings, %0d csr writes",
               items_sent, csr_writes);
      $display("results %0d: %0d samples, %0d quarter and %0d half strobes, %0d irq reads",
               results_seen, samples_seen, quarters_seen, halves_seen, irq_reports);
      if (mismatches == 0) begin
         $display("apu_frame_sequencer_and_mixer_test passed");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("apu_frame_sequencer_and_mixer_test failed");
      end
      $finish;
   end

endmodule
